[src/assert_macros.svh]
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[src/lerf_pkg.sv]
package lerf_pkg;

	localparam int ID_W     = 32;
	localparam int STAMP_W  = 64;
	localparam int WIN_W    = 32;
	localparam int LEVEL_W  = 3;
	localparam int MASK_W   = 4;
	localparam int THR_W    = 12;
	localparam int CAPREQ_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 32;

	// request codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_IDLE  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN3   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 3'd6;

	localparam logic [THR_W-1:0]   THRESH_RST = 12'd1755;
	localparam logic [LEVEL_W-1:0] FLOOR_RST  = 3'd2;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	// true while now is still before base + win (signed wrapping compare)
	function automatic logic time_before(input logic [STAMP_W-1:0] now,
			input logic [STAMP_W-1:0] base, input logic [WIN_W-1:0] win);
		logic [STAMP_W-1:0] diff;
		diff = now - (base + {{(STAMP_W-WIN_W){1'b0}}, win});
		return diff[STAMP_W-1];
	endfunction

	// smallest power of two not below req, zero for zero
	function automatic logic [CAPREQ_W:0] round_pow2(input logic [CAPREQ_W-1:0] req);
		logic [CAPREQ_W:0] cap;
		cap = (req == '0) ? '0 : {{CAPREQ_W{1'b0}}, 1'b1};
		for (int i = 0; i < CAPREQ_W; i++) begin
			if (cap != '0 && cap < {1'b0, req})
				cap = cap << 1;
		end
		return cap;
	endfunction

endpackage

[src/lerf_cell.sv]
// one table slot: shifts toward the head or takes the tail write
module lerf_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = 1
) (
	input  logic                 clk,
	input  lerf_pkg::cell_ctrl_t ctrl,
	input  logic [IDX_W-1:0]     tail_idx,
	input  lerf_pkg::entry_t     tail_data,
	input  lerf_pkg::entry_t     nbr,
	output lerf_pkg::entry_t     cur
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	lerf_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.load && tail_idx == MY_IDX)
			entry_q <= tail_data;
		else if (ctrl.shift)
			entry_q <= nbr;
	end

	assign cur = entry_q;

endmodule

[src/log_entry_rate_filter_top.sv]
// log entry rate filter: for each log write event, returns a mask of the destinations that
// take it, from per-destination severity thresholds and, when rate filtering is active
// (nonzero capacity, some nonzero window, severity at or above the floor), from the time
// since the event id was last seen in a table of recent ids kept in insertion order. the
// table is a row of TABLE_DEPTH cells that shifts one slot toward the head every cycle of a
// walk; the head entry is checked and either written back at the tail or dropped, so one
// walk visits every entry in order and leaves the order intact. a filtered write event of a
// new id goes through the walk, an append step and an output step, a known id and an idle
// tick through the walk and the output step, and an unfiltered event through the output
// step only; an empty table skips the walk. one item is in work at a time, and a new item
// is taken while the previous result still waits in the output register. configuration
// must be written only while the block is idle; the block itself does not enforce this.
// an accepted capacity write empties the table, so no clearing pass is needed
`include "assert_macros.svh"

module log_entry_rate_filter_top #(
	parameter int TABLE_DEPTH = 64,
	parameter int NUM_DEST    = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_write,
	input  logic [lerf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lerf_pkg::CFG_W-1:0]          cfg_data,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [lerf_pkg::ID_W-1:0]           message_id,
	input  logic [lerf_pkg::STAMP_W-1:0]        stamp,
	input  logic [lerf_pkg::LEVEL_W-1:0]        level,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lerf_pkg::MASK_W-1:0]         deliver_mask
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CAP_CMP_W = 9;

	// controller states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_APPEND = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	// configuration registers
	logic [lerf_pkg::THR_W-1:0]   thresh_q;
	logic [lerf_pkg::WIN_W-1:0]   windows_q [4];
	logic [lerf_pkg::WIN_W-1:0]   win_nxt [4];
	logic [lerf_pkg::WIN_W-1:0]   longest_q;
	logic [lerf_pkg::WIN_W-1:0]   longest_nxt;
	logic [CNT_W-1:0]             eff_cap_q;
	logic [lerf_pkg::LEVEL_W-1:0] floor_q;
	logic [lerf_pkg::CAPREQ_W:0]  cap_req;
	logic                         cap_ok;

	// controller and item registers
	logic [1:0]                   state_q;
	logic [CNT_W-1:0]             fill_q;
	logic [CNT_W-1:0]             fill_m1;
	logic [CNT_W-1:0]             rem_q;
	logic                         found_q;
	logic                         func_q;
	logic [lerf_pkg::ID_W-1:0]    id_q;
	logic [lerf_pkg::STAMP_W-1:0] now_q;
	logic [lerf_pkg::MASK_W-1:0]  mask_q;
	logic                         out_valid_q;
	logic [lerf_pkg::MASK_W-1:0]  deliver_mask_q;

	// cell row
	lerf_pkg::entry_t     cell_out [TABLE_DEPTH];
	lerf_pkg::entry_t     head;
	lerf_pkg::entry_t     tail_data;
	lerf_pkg::cell_ctrl_t cell_ctrl;
	logic [IDX_W-1:0]     tail_idx;

	logic                         in_xfer;
	logic                         filter_on;
	logic [lerf_pkg::MASK_W-1:0]  thr_mask;
	logic [lerf_pkg::MASK_W-1:0]  drop_mask;
	logic                         hit;
	logic                         keep_idle;
	logic                         tab_full;
	logic [lerf_pkg::CFG_IDX_W-1:0] widx;

	// ---------------------------------------------------------------- configuration

	assign widx = cfg_index - lerf_pkg::REG_WIN0;

	always_comb begin
		for (int k = 0; k < 4; k++)
			win_nxt[k] = windows_q[k];
		if (cfg_write && cfg_index >= lerf_pkg::REG_WIN0 && cfg_index <= lerf_pkg::REG_WIN3)
			win_nxt[widx[1:0]] = cfg_data;
		// longest window over the destinations that exist
		longest_nxt = '0;
		for (int k = 0; k < 4; k++) begin
			if (k < NUM_DEST && win_nxt[k] > longest_nxt)
				longest_nxt = win_nxt[k];
		end
	end

	// requested capacity rounded up; refused when it overflows the table
	assign cap_req = lerf_pkg::round_pow2(cfg_data[lerf_pkg::CAPREQ_W-1:0]);
	assign cap_ok  = CAP_CMP_W'(cap_req) <= CAP_CMP_W'(TABLE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= lerf_pkg::THRESH_RST;
			floor_q   <= lerf_pkg::FLOOR_RST;
			longest_q <= '0;
			for (int k = 0; k < 4; k++)
				windows_q[k] <= '0;
		end else begin
			for (int k = 0; k < 4; k++)
				windows_q[k] <= win_nxt[k];
			longest_q <= longest_nxt;
			if (cfg_write && cfg_index == lerf_pkg::REG_THRESH)
				thresh_q <= cfg_data[lerf_pkg::THR_W-1:0];
			if (cfg_write && cfg_index == lerf_pkg::REG_FLOOR)
				floor_q <= cfg_data[lerf_pkg::LEVEL_W-1:0];
		end
	end

	// ---------------------------------------------------------------- per-item decisions

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// threshold pass per destination, absent destinations never pass
	always_comb begin
		thr_mask = '0;
		for (int k = 0; k < lerf_pkg::MASK_W; k++) begin
			if (k < NUM_DEST && level >= thresh_q[3*k +: 3])
				thr_mask[k] = 1'b1;
		end
	end

	assign filter_on = (eff_cap_q != '0) && (longest_q != '0) && (level >= floor_q);

	// ---------------------------------------------------------------- walk datapath

	assign head      = cell_out[0];
	assign fill_m1   = fill_q - CNT_W'(1);
	assign tab_full  = fill_q >= eff_cap_q;
	assign hit       = (func_q == lerf_pkg::FUNC_WRITE) && !found_q && (head.id == id_q);
	// idle tick keeps an entry until its longest window has run out
	assign keep_idle = lerf_pkg::time_before(now_q, head.stamp, longest_q);

	// destinations whose window has not yet run out for the matching entry
	always_comb begin
		drop_mask = '0;
		for (int k = 0; k < lerf_pkg::MASK_W; k++) begin
			if (k < NUM_DEST && windows_q[k] != '0 &&
					lerf_pkg::time_before(now_q, head.stamp, windows_q[k]))
				drop_mask[k] = 1'b1;
		end
	end

	always_comb begin
		cell_ctrl       = '0;
		tail_idx        = fill_q[IDX_W-1:0];
		tail_data.id    = head.id;
		tail_data.stamp = head.stamp;
		unique case (state_q)
			ST_SCAN: begin
				// head leaves, written back at the tail unless purged
				cell_ctrl.shift = 1'b1;
				cell_ctrl.load  = (func_q == lerf_pkg::FUNC_IDLE) ? keep_idle : 1'b1;
				tail_idx        = fill_m1[IDX_W-1:0];
				if (hit)
					tail_data.stamp = now_q;
			end
			ST_APPEND: begin
				// new id at the tail, evicting the oldest when full
				tail_data.id    = id_q;
				tail_data.stamp = now_q;
				cell_ctrl.load  = 1'b1;
				if (tab_full) begin
					cell_ctrl.shift = 1'b1;
					tail_idx        = fill_m1[IDX_W-1:0];
				end
			end
			ST_IDLE, ST_EMIT: begin
				cell_ctrl = '0;
			end
		endcase
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		lerf_pkg::entry_t nbr;
		if (g == TABLE_DEPTH - 1) begin : g_last
			assign nbr = cell_out[g];
		end else begin : g_mid
			assign nbr = cell_out[g+1];
		end
		lerf_cell #(
			.INDEX (g),
			.IDX_W (IDX_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.tail_idx  (tail_idx),
			.tail_data (tail_data),
			.nbr       (nbr),
			.cur       (cell_out[g])
		);
	end

	// ---------------------------------------------------------------- controller

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fill_q         <= '0;
			eff_cap_q      <= '0;
			rem_q          <= '0;
			found_q        <= 1'b0;
			func_q         <= lerf_pkg::FUNC_WRITE;
			id_q           <= '0;
			now_q          <= '0;
			mask_q         <= '0;
			out_valid_q    <= 1'b0;
			deliver_mask_q <= '0;
		end else begin
			// result register drains on a transfer, unless a new result takes its place
			if (out_valid_q && !out_stall && state_q != ST_EMIT)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						func_q  <= func;
						id_q    <= message_id;
						now_q   <= stamp;
						found_q <= 1'b0;
						rem_q   <= fill_q;
						if (func == lerf_pkg::FUNC_IDLE) begin
							mask_q  <= '0;
							state_q <= (fill_q != '0) ? ST_SCAN : ST_EMIT;
						end else if (!filter_on) begin
							mask_q  <= thr_mask;
							state_q <= ST_EMIT;
						end else begin
							mask_q  <= thr_mask;
							state_q <= (fill_q != '0) ? ST_SCAN : ST_APPEND;
						end
					end
				end
				ST_SCAN: begin
					rem_q <= rem_q - CNT_W'(1);
					if (func_q == lerf_pkg::FUNC_IDLE && !keep_idle)
						fill_q <= fill_m1;
					if (hit) begin
						found_q <= 1'b1;
						mask_q  <= mask_q & ~drop_mask;
					end
					if (rem_q == CNT_W'(1)) begin
						if (func_q == lerf_pkg::FUNC_IDLE || found_q || hit)
							state_q <= ST_EMIT;
						else
							state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					if (!tab_full)
						fill_q <= fill_q + CNT_W'(1);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						deliver_mask_q <= mask_q;
						state_q        <= ST_IDLE;
					end
				end
			endcase

			// an accepted capacity write empties the table
			if (cfg_write && cfg_index == lerf_pkg::REG_CAP && cap_ok) begin
				eff_cap_q <= CNT_W'(cap_req);
				fill_q    <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign deliver_mask = deliver_mask_q;

	// ---------------------------------------------------------------- checks

	`ASSERT_ALWAYS(a_fill_in_cap, fill_q <= eff_cap_q, "table fill beyond capacity")
	`ASSERT_IMPLIES(a_scan_rem, state_q == ST_SCAN, rem_q != '0, "walk with no entries left")
	`ASSERT_IMPLIES(a_idle_zero, state_q == ST_EMIT && func_q == lerf_pkg::FUNC_IDLE,
		mask_q == '0, "idle tick with nonzero mask")
	`ASSERT_IMPLIES(a_append_cap, state_q == ST_APPEND, eff_cap_q != '0,
		"append with filtering off")

endmodule

[test/lerf_delivery_check.sv]
module lerf_delivery_check
	import lerf_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int NUM_DEST    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 func,
	input  logic [ID_W-1:0]      message_id,
	input  logic [STAMP_W-1:0]   stamp,
	input  logic [LEVEL_W-1:0]   level,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [MASK_W-1:0]    deliver_mask,
	output int                   mismatches,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow of the registers and of the id table
	logic [THR_W-1:0]   thr_bits;
	logic [WIN_W-1:0]   win [4];
	logic [WIN_W-1:0]   win_max;
	logic [CAPREQ_W:0]  cap_eff;
	logic [LEVEL_W-1:0] floor_lvl;
	logic [ID_W-1:0]    ids [TABLE_DEPTH];
	logic [STAMP_W-1:0] seen_at [TABLE_DEPTH];
	int                 fill;
	logic [MASK_W-1:0]  masks_due [$];
	int                 results_seen;

	// set while now has not yet reached base + w
	function automatic logic still_inside(input logic [STAMP_W-1:0] now,
			input logic [STAMP_W-1:0] base, input logic [WIN_W-1:0] w);
		logic [STAMP_W-1:0] gap;
		gap = now - (base + STAMP_W'(w));
		return gap[STAMP_W-1];
	endfunction

	function automatic void drop_entry(input int pos);
		for (int k = pos; k + 1 < fill; k++) begin
			ids[k] = ids[k + 1];
			seen_at[k] = seen_at[k + 1];
		end
		fill--;
	endfunction

	function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		logic [CAPREQ_W-1:0] req;
		logic [CAPREQ_W:0]   cap;
		case (idx)
			REG_THRESH: thr_bits = data[THR_W-1:0];
			REG_FLOOR:  floor_lvl = data[LEVEL_W-1:0];
			REG_CAP: begin
				req = data[CAPREQ_W-1:0];
				cap = (req == '0) ? '0 : (CAPREQ_W + 1)'(1);
				while (cap < {1'b0, req})
					cap = cap << 1;
				// too large for the table: write has no effect
				if (cap <= TABLE_DEPTH) begin
					cap_eff = cap;
					fill = 0;
				end
			end
			default: begin
				if (idx >= REG_WIN0 && idx <= REG_WIN3) begin
					win[2'(idx - REG_WIN0)] = data[WIN_W-1:0];
					win_max = '0;
					for (int k = 0; k < NUM_DEST; k++)
						if (win[k] > win_max)
							win_max = win[k];
				end
			end
		endcase
	endfunction

	function automatic logic [MASK_W-1:0] route_event(input logic f,
			input logic [ID_W-1:0] id, input logic [STAMP_W-1:0] now,
			input logic [LEVEL_W-1:0] lv);
		logic [MASK_W-1:0] mask;
		logic              hit;
		int                pos;
		int                k;
		mask = '0;
		if (f == FUNC_IDLE) begin
			k = 0;
			while (k < fill) begin
				if (!still_inside(now, seen_at[k], win_max))
					drop_entry(k);
				else
					k++;
			end
			return '0;
		end
		if (cap_eff == '0 || win_max == '0 || lv < floor_lvl) begin
			for (k = 0; k < NUM_DEST; k++)
				if (lv >= thr_bits[LEVEL_W*k +: LEVEL_W])
					mask[k] = 1'b1;
			return mask;
		end
		hit = 1'b0;
		pos = 0;
		for (k = 0; k < fill; k++) begin
			if (ids[k] == id) begin
				hit = 1'b1;
				pos = k;
				break;
			end
		end
		for (k = 0; k < NUM_DEST; k++) begin
			if (lv >= thr_bits[LEVEL_W*k +: LEVEL_W] &&
					!(hit && win[k] != '0 && still_inside(now, seen_at[pos], win[k])))
				mask[k] = 1'b1;
		end
		if (!hit) begin
			if (fill >= cap_eff)
				drop_entry(0);
			pos = fill;
			ids[pos] = id;
			fill++;
		end
		seen_at[pos] = now;
		return mask;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [MASK_W-1:0] want;
		if (!arst_n) begin
			thr_bits = THRESH_RST;
			for (int k = 0; k < 4; k++)
				win[k] = '0;
			win_max = '0;
			cap_eff = '0;
			floor_lvl = FLOOR_RST;
			fill = 0;
			masks_due.delete();
			results_seen = 0;
			mismatches = 0;
		end else begin
			if (cfg_write)
				apply_register_write(cfg_index, cfg_data);
			if (out_valid && !out_stall) begin
				if (masks_due.size() == 0) begin
					if (mismatches < 10)
						$display("result %0d: deliver_mask %h with no transfer waiting",
							results_seen, deliver_mask);
					mismatches++;
				end else begin
					want = masks_due.pop_front();
					if (deliver_mask !== want) begin
						if (mismatches < 10)
							$display("result %0d: deliver_mask expected %h, got %h",
								results_seen, want, deliver_mask);
						mismatches++;
					end
				end
				results_seen++;
			end
			if (in_valid && !in_stall)
				masks_due.push_back(route_event(func, message_id, stamp, level));
		end
		pending = masks_due.size();
	end

endmodule

[test/tb_log_entry_rate_filter_top.sv]
module tb_log_entry_rate_filter_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lerf_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int NUM_DEST     = 4;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;
	// worst case is far below this: ~1650 transfers plus stalls
	localparam int LIMIT        = 1000000;
	// receiver hold-off that fills the block up
	localparam int LONG_HOLD    = 400;
	// a filtered write walks every entry in the table
	localparam int DRAIN_CYCLES = 80;
	// no register sits at this index
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 func = FUNC_WRITE;
	logic [ID_W-1:0]      message_id = '0;
	logic [STAMP_W-1:0]   stamp = '0;
	logic [LEVEL_W-1:0]   level = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [MASK_W-1:0]    deliver_mask;
	int                   mismatches;
	int                   pending;

	int                   cycles = 0;
	// calm stretches: neither side idles
	bit                   calm = 1'b0;
	int                   holds_asked = 0;
	int                   holds_done = 0;
	// running time base, its step size and the ids that recur in a phase
	logic [STAMP_W-1:0]   now_tick;
	int                   scale;
	logic [ID_W-1:0]      id_pool [128];
	int                   pool_n;

	log_entry_rate_filter_top #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.NUM_DEST   (NUM_DEST)
	) DUT (.*);

	lerf_delivery_check #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.NUM_DEST   (NUM_DEST)
	) delivery_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb_log_entry_rate_filter_top failed");
			$finish;
		end
	end

	// mostly no gap, sometimes a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [WIN_W-1:0] pick_window();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return '0;
		if (r < 70)
			return $urandom_range(400, 1);
		if (r < 88)
			return $urandom;
		return '1;
	endfunction

	// one request transfer; entered and left at a falling edge, valid stays high
	// so that back-to-back transfers need no second assignment in a step
	task automatic send_item(input logic f, input logic [ID_W-1:0] id,
			input logic [STAMP_W-1:0] st, input logic [LEVEL_W-1:0] lv);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = f;
		message_id = id;
		stamp = st;
		level = lv;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// quiet the request side and wait for every expected result
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic pick_settings(input int ph);
		logic [CFG_W-1:0] cap_req;
		if (ph == 0 || $urandom_range(99) < 60)
			write_reg(REG_THRESH, (ph == 0) ? '0 :
				(ph == PHASES - 1) ? CFG_W'(12'hFFF) : CFG_W'($urandom_range(4095)));
		// phase 2: every window at its maximum, phase 3: all windows off
		for (int k = 0; k < 4; k++)
			if (ph <= 3 || $urandom_range(99) < 70)
				write_reg(CFG_IDX_W'(REG_WIN0 + k),
					(ph == 2) ? '1 : (ph == 3) ? '0 : pick_window());
		case (ph)
			1:       cap_req = 64;
			4:       cap_req = 1;
			5:       cap_req = 127;
			default: cap_req = ($urandom_range(99) < 15) ? $urandom_range(127, 65) :
				$urandom_range(64);
		endcase
		// skipping the capacity write keeps the table across phases
		if (ph <= 5 || $urandom_range(99) < 60)
			write_reg(REG_CAP, cap_req);
		if ($urandom_range(99) < 60)
			write_reg(REG_FLOOR, $urandom_range(7));
		if ($urandom_range(99) < 30)
			write_reg(REG_UNUSED, $urandom);
		scale = $urandom_range(300, 1);
		pool_n = $urandom_range((ph % 2) ? 8 : 96, 1);
		for (int i = 0; i < pool_n; i++)
			id_pool[i] = $urandom;
		// phases 3 and 6 start near the signed and the unsigned wrap
		if (ph == 3)
			now_tick = 64'h7FFF_FFFF_FFFF_F000;
		else if (ph == 6)
			now_tick = 64'hFFFF_FFFF_FFFF_F000;
		else
			now_tick = {$urandom, $urandom};
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 8) begin
			now_tick += STAMP_W'($urandom_range(2 * scale));
			send_item(FUNC_IDLE, $urandom, now_tick, LEVEL_W'($urandom_range(7)));
		end else if (r < 16) begin
			// noise: fresh id, arbitrary time point
			send_item(FUNC_WRITE, $urandom, {$urandom, $urandom},
				LEVEL_W'($urandom_range(7)));
		end else begin
			// recurring ids on a mostly advancing time base
			r = $urandom_range(99);
			if (r < 4)
				now_tick -= STAMP_W'($urandom_range(3 * scale));
			else if (r < 6)
				now_tick += {$urandom, $urandom};
			else
				now_tick += STAMP_W'($urandom_range(scale));
			send_item(FUNC_WRITE, id_pool[7'($urandom_range(pool_n - 1))], now_tick,
				LEVEL_W'($urandom_range(7)));
		end
	endtask

	// result side: random stalls, calm stretches, and the long hold-off
	initial begin
		int r;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_done < holds_asked) begin
				// sender keeps offering, so the block fills up and stalls its input
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall = 1'b0;
				holds_done++;
			end else if (calm) begin
				out_stall = 1'b0;
			end else begin
				r = $urandom_range(99);
				out_stall = (r >= 65);
				if (r >= 97)
					repeat ($urandom_range(40, 12)) @(negedge clk);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: threshold 3 everywhere, no filtering
		send_item(FUNC_WRITE, '0, '0, 3'd0);
		send_item(FUNC_WRITE, '1, '1, 3'd7);
		send_item(FUNC_IDLE, 32'h5555_AAAA, 64'd0, 3'd3);

		// thresholds 0/2/5/7, windows 10/off/100/max, capacity 3 rounds up to 4
		settle();
		write_reg(REG_THRESH, CFG_W'({3'd7, 3'd5, 3'd2, 3'd0}));
		write_reg(REG_WIN0, 32'd10);
		write_reg(REG_WIN0 + 3'd1, 32'd0);
		write_reg(REG_WIN0 + 3'd2, 32'd100);
		write_reg(REG_WIN3, '1);
		write_reg(REG_CAP, 32'd3);
		write_reg(REG_FLOOR, 32'd1);
		send_item(FUNC_WRITE, 32'h1, 64'd1000, 3'd7);
		// repeat inside the windows
		send_item(FUNC_WRITE, 32'h1, 64'd1005, 3'd7);
		// destination 0 window exactly over
		send_item(FUNC_WRITE, 32'h1, 64'd1015, 3'd7);
		// below the floor: thresholds only, time not touched
		send_item(FUNC_WRITE, 32'h1, 64'd1016, 3'd0);
		send_item(FUNC_WRITE, '1, 64'd1020, 3'd5);
		send_item(FUNC_WRITE, '0, 64'd1021, 3'd3);
		send_item(FUNC_WRITE, 32'h8000_0000, 64'd1022, 3'd6);
		// table full: oldest id is evicted
		send_item(FUNC_WRITE, 32'h1234_5678, 64'd1023, 3'd7);
		// the evicted id comes back as a new one
		send_item(FUNC_WRITE, 32'h1, 64'd1024, 3'd7);
		// time going backwards
		send_item(FUNC_WRITE, 32'h1, 64'd1000, 3'd7);
		// longest window at maximum: nothing expires
		send_item(FUNC_IDLE, '0, 64'd1050, 3'd0);
		// window write keeps the table; purge lands exactly on one entry's expiry
		settle();
		write_reg(REG_WIN3, 32'd0);
		send_item(FUNC_IDLE, '0, 64'd1122, 3'd0);
		// across the unsigned wrap, then a jump of half the range
		send_item(FUNC_WRITE, 32'h0F0F_0F0F, 64'hFFFF_FFFF_FFFF_FFFC, 3'd7);
		send_item(FUNC_WRITE, 32'h0F0F_0F0F, 64'd3, 3'd7);
		send_item(FUNC_WRITE, 32'h0F0F_0F0F, 64'h8000_0000_0000_0010, 3'd7);
		// capacity too large: ignored, table kept
		settle();
		write_reg(REG_CAP, 32'd65);
		send_item(FUNC_WRITE, 32'h0F0F_0F0F, 64'h8000_0000_0000_0012, 3'd7);
		// single entry table, floor at maximum, write to the unused index
		settle();
		write_reg(REG_CAP, 32'd1);
		write_reg(REG_UNUSED, '1);
		write_reg(REG_FLOOR, 32'd7);
		send_item(FUNC_WRITE, 32'h1, 64'd2000, 3'd7);
		send_item(FUNC_WRITE, 32'h1, 64'd2001, 3'd7);
		send_item(FUNC_WRITE, 32'h2, 64'd2002, 3'd6);
		send_item(FUNC_WRITE, 32'h2, 64'd2003, 3'd7);
		send_item(FUNC_WRITE, 32'h1, 64'd2004, 3'd7);
		// capacity zero turns filtering off
		settle();
		write_reg(REG_CAP, 32'd0);
		send_item(FUNC_WRITE, 32'h1, 64'd2005, 3'd7);

		// random phases, each with its own register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			pick_settings(ph);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 40 == 0)
					calm = ($urandom_range(99) < 25);
				if ((ph == 2 || ph == 5) && i == 50)
					holds_asked++;
				random_item();
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb_log_entry_rate_filter_top passed");
		else
			$display("tb_log_entry_rate_filter_top failed");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/lerf_pkg.sv
src/lerf_cell.sv
src/log_entry_rate_filter_top.sv
test/lerf_delivery_check.sv
test/tb_log_entry_rate_filter_top.sv
